FILE: rtl/core/chip8_instruction_executor_core_defines.svh
// ----------------------------------------------------------------------------
// chip8_instruction_executor_core_defines
// Assertion macros shared by the executor core.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH

// same-cycle implication
`define C8X_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c8x: check failed");

// next-cycle implication
`define C8X_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c8x: check failed");

`endif

FILE: rtl/core/c8x_pkg.sv
// ----------------------------------------------------------------------------
// c8x_pkg
// Types, constants and helper functions of the CHIP-8 executor core.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int MEM_DEPTH   = 4096;
  localparam int AW          = $clog2(MEM_DEPTH);
  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SCR_W       = 64;
  localparam int SCR_H       = 32;
  localparam int NREG        = 16;
  localparam int FONT_LEN    = 80;

  localparam logic [AW-1:0] PC_START = AW'(12'h200);
  localparam logic [3:0]    VF_IDX   = 4'hF;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_EXEC = 3'd1;
  localparam logic [2:0] OP_TICK = 3'd2;
  localparam logic [2:0] OP_KEY  = 3'd3;
  localparam logic [2:0] OP_ROW  = 3'd4;

  localparam logic [7:0] LO_CLS   = 8'hE0;
  localparam logic [7:0] LO_RET   = 8'hEE;
  localparam logic [7:0] LO_SKP   = 8'h9E;
  localparam logic [7:0] LO_SKNP  = 8'hA1;
  localparam logic [7:0] LO_GDT   = 8'h07;
  localparam logic [7:0] LO_KWAIT = 8'h0A;
  localparam logic [7:0] LO_SDT   = 8'h15;
  localparam logic [7:0] LO_SST   = 8'h18;
  localparam logic [7:0] LO_ADDI  = 8'h1E;
  localparam logic [7:0] LO_FONT  = 8'h29;
  localparam logic [7:0] LO_BCD   = 8'h33;
  localparam logic [7:0] LO_SAVE  = 8'h55;
  localparam logic [7:0] LO_REST  = 8'h65;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef enum logic [3:0] {
    GRP_SYS, GRP_JP, GRP_CALL, GRP_SE, GRP_SNE, GRP_SER, GRP_LD, GRP_ADD,
    GRP_ALU, GRP_SNER, GRP_LDI, GRP_JPV, GRP_RND, GRP_DRW, GRP_KEY, GRP_MISC
  } grp_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLR, CMD_CAPTURE, CMD_LOAD, CMD_MISC, CMD_FETCH_HI,
    CMD_FETCH_LO, CMD_RD_X, CMD_RD_Y, CMD_RD_0, CMD_EXEC, CMD_FLAG,
    CMD_DRAW_RD, CMD_DRAW_WR, CMD_BCD, CMD_SAVE_RD, CMD_SAVE_WR,
    CMD_REST_RD, CMD_REST_WR, CMD_FINISH
  } cmd_t;

  typedef enum logic [2:0] {
    NX_DONE, NX_FLAG, NX_DRAW, NX_BCD, NX_SAVE, NX_REST
  } nxt_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [4:0]    step;
    logic [AW-1:0] clr_addr;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    nxt_t       nxt;
    logic [4:0] count;
    logic       out_busy;
  } st_t;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // {hundreds, tens, units}, one nibble each
  function automatic logic [11:0] bcd3(input logic [7:0] v);
    logic [1:0] h;
    logic [7:0] rr;
    logic [6:0] r;
    logic [3:0] t;
    logic [3:0] o;
    h  = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rr = v - 8'(h) * 8'd100;
    r  = rr[6:0];
    t  = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= 7'(k * 10)) t = 4'(k);
    end
    o = 4'(r - 7'(t) * 7'd10);
    return {2'b00, h, t, o};
  endfunction

endpackage

FILE: rtl/core/c8x_in_if.sv
// ----------------------------------------------------------------------------
// c8x_in_if
// Item channel of the executor core: valid/ready plus item fields.
// ----------------------------------------------------------------------------
interface c8x_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [11:0] load_address;
  logic [7:0]  load_data;
  logic [7:0]  random_byte;
  logic [3:0]  key_index;
  logic [4:0]  row_index;

  modport source (output valid, operation, load_address, load_data, random_byte,
                  key_index, row_index, input ready);
  modport sink   (input valid, operation, load_address, load_data, random_byte,
                  key_index, row_index, output ready);
endinterface

FILE: rtl/core/c8x_out_if.sv
// ----------------------------------------------------------------------------
// c8x_out_if
// Result channel of the executor core: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface c8x_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [63:0] row_bits;
  logic        status;

  modport source (output valid, program_counter, row_bits, status, input ready);
  modport sink   (input valid, program_counter, row_bits, status, output ready);
endinterface

FILE: rtl/core/c8x_ram.sv
// ----------------------------------------------------------------------------
// c8x_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8x_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/c8x_ctrl.sv
// ----------------------------------------------------------------------------
// c8x_ctrl
// Sequencer: memory init pass, item dispatch, fetch, and multi-beat loops.
// ----------------------------------------------------------------------------
module c8x_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output c8x_pkg::ctl_t ctl,
  input  c8x_pkg::st_t  st
);
  import c8x_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_LOAD, S_MISC, S_FHI, S_FLO, S_RDX, S_RDY, S_RD0,
    S_EXEC, S_FLAG, S_DRD, S_DWR, S_BCD, S_SRD, S_SWR, S_LRD, S_LWR, S_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  cmd_t          cmd;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd     = CMD_CLR;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.op)
          OP_LOAD: state_nxt = S_LOAD;
          OP_EXEC: state_nxt = S_FHI;
          default: state_nxt = S_MISC;
        endcase
      end
      S_LOAD: begin cmd = CMD_LOAD;     state_nxt = S_FIN; end
      S_MISC: begin cmd = CMD_MISC;     state_nxt = S_FIN; end
      S_FHI:  begin cmd = CMD_FETCH_HI; state_nxt = S_FLO; end
      S_FLO:  begin cmd = CMD_FETCH_LO; state_nxt = S_RDX; end
      S_RDX:  begin cmd = CMD_RD_X;     state_nxt = S_RDY; end
      S_RDY:  begin cmd = CMD_RD_Y;     state_nxt = S_RD0; end
      S_RD0:  begin cmd = CMD_RD_0;     state_nxt = S_EXEC; end
      S_EXEC: begin
        cmd      = CMD_EXEC;
        step_nxt = '0;
        unique case (st.nxt)
          NX_FLAG: state_nxt = S_FLAG;
          NX_DRAW: state_nxt = S_DRD;
          NX_BCD:  state_nxt = S_BCD;
          NX_SAVE: state_nxt = S_SRD;
          NX_REST: state_nxt = S_LRD;
          default: state_nxt = S_FIN;
        endcase
      end
      S_FLAG: begin cmd = CMD_FLAG; state_nxt = S_FIN; end
      S_DRD: begin
        if (step_r == st.count) begin
          state_nxt = S_FLAG;
        end else begin
          cmd       = CMD_DRAW_RD;
          state_nxt = S_DWR;
        end
      end
      S_DWR: begin
        cmd       = CMD_DRAW_WR;
        step_nxt  = step_r + 1'b1;
        state_nxt = S_DRD;
      end
      S_BCD: begin
        if (step_r == st.count) begin
          state_nxt = S_FIN;
        end else begin
          cmd      = CMD_BCD;
          step_nxt = step_r + 1'b1;
        end
      end
      S_SRD: begin
        if (step_r == st.count) begin
          state_nxt = S_FIN;
        end else begin
          cmd       = CMD_SAVE_RD;
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        cmd       = CMD_SAVE_WR;
        step_nxt  = step_r + 1'b1;
        state_nxt = S_SRD;
      end
      S_LRD: begin
        if (step_r == st.count) begin
          state_nxt = S_FIN;
        end else begin
          cmd       = CMD_REST_RD;
          state_nxt = S_LWR;
        end
      end
      S_LWR: begin
        cmd       = CMD_REST_WR;
        step_nxt  = step_r + 1'b1;
        state_nxt = S_LRD;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd       = CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready     = (state_r == S_IDLE);
  assign ctl.cmd      = cmd;
  assign ctl.step     = step_r;
  assign ctl.clr_addr = clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      step_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      clr_r   <= clr_nxt;
    end
  end
endmodule

FILE: rtl/core/c8x_dpath.sv
// ----------------------------------------------------------------------------
// c8x_dpath
// Machine state, memories, instruction decode and execute, result register.
// ----------------------------------------------------------------------------
module c8x_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  c8x_pkg::ctl_t ctl,
  output c8x_pkg::st_t  st,
  input  logic [2:0]    in_operation,
  input  logic [11:0]   in_load_address,
  input  logic [7:0]    in_load_data,
  input  logic [7:0]    in_random_byte,
  input  logic [3:0]    in_key_index,
  input  logic [4:0]    in_row_index,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [11:0]   out_program_counter,
  output logic [63:0]   out_row_bits,
  output logic          out_status
);
  import c8x_pkg::*;

  // captured item
  logic [2:0]    op_r;
  logic [AW-1:0] ld_addr_r;
  logic [7:0]    ld_data_r;
  logic [7:0]    rnd_r;
  logic [3:0]    key_idx_r;
  logic [4:0]    row_idx_r;

  // machine state
  logic [AW-1:0]    pc_r, i_r;
  logic [SP_W-1:0]  sp_r;
  logic [7:0]       timer_r;
  logic [NREG-1:0]  keys_r;
  logic [AW-1:0]    stack_r [STACK_DEPTH];
  logic [SCR_W-1:0] scr_r [SCR_H];
  logic [NREG-1:0]  v_valid_r;
  logic             v_vld_q_r;

  // working registers
  logic [7:0] hi_r, lo_r, vx_r, vy_r;
  logic       flag_r;
  logic [4:0] cnt_r;
  logic       bad_r;
  logic [SCR_W-1:0] rowout_r;
  logic             out_valid_r;
  logic [AW-1:0]    out_pc_r;
  logic [SCR_W-1:0] out_row_r;
  logic             out_st_r;

  // memories
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [7:0]    m_wdata, m_rdata;
  logic          v_we;
  logic [3:0]    v_waddr, v_raddr;
  logic [7:0]    v_wdata, v_rdata, v_out;

  c8x_ram #(.W(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  c8x_ram #(.W(8), .DEPTH(NREG)) u_vreg (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata)
  );

  assign v_out = v_vld_q_r ? v_rdata : 8'h00;

  // decode and execute
  grp_t          grp;
  logic [3:0]    fx, fn;
  logic [AW-1:0] nnn, pc2, pc4;
  logic [SP_W-1:0] sp_m1;
  logic          key_hit;
  logic [5:0]    row_room;
  logic [8:0]    sum9;
  logic [AW-1:0] e_pc, e_ival;
  logic          e_vwe, e_iwe, e_twe, e_keyclr, e_push, e_pop, e_cls, e_bad, e_fval;
  logic [7:0]    e_vval;
  nxt_t          e_nxt;
  logic [4:0]    e_cnt;

  always_comb begin
    grp      = grp_t'(hi_r[7:4]);
    fx       = hi_r[3:0];
    fn       = lo_r[3:0];
    nnn      = {hi_r[3:0], lo_r};
    pc2      = pc_r + AW'(2);
    pc4      = pc_r + AW'(4);
    sp_m1    = sp_r - 1'b1;
    key_hit  = (vx_r[7:4] == 4'h0) && keys_r[vx_r[3:0]];
    row_room = 6'(SCR_H) - {1'b0, vy_r[4:0]};
    sum9     = '0;
    e_pc     = pc2;
    e_ival   = i_r;
    e_vwe    = 1'b0;
    e_vval   = 8'h00;
    e_iwe    = 1'b0;
    e_twe    = 1'b0;
    e_keyclr = 1'b0;
    e_push   = 1'b0;
    e_pop    = 1'b0;
    e_cls    = 1'b0;
    e_bad    = 1'b0;
    e_fval   = 1'b0;
    e_nxt    = NX_DONE;
    e_cnt    = '0;
    unique case (grp)
      GRP_SYS: begin
        if (fx == 4'h0 && lo_r == LO_CLS) begin
          e_cls = 1'b1;
        end else if (fx == 4'h0 && lo_r == LO_RET) begin
          if (sp_r != '0) begin
            e_pop = 1'b1;
            e_pc  = stack_r[sp_m1[STK_AW-1:0]];
          end
        end else begin
          e_bad = 1'b1;
        end
      end
      GRP_JP: e_pc = nnn;
      GRP_CALL: begin
        if (sp_r < SP_W'(STACK_DEPTH)) begin
          e_push = 1'b1;
          e_pc   = nnn;
        end
      end
      GRP_SE:  if (vx_r == lo_r) e_pc = pc4;
      GRP_SNE: if (vx_r != lo_r) e_pc = pc4;
      GRP_SER: begin
        if (fn != 4'h0) e_bad = 1'b1;
        else if (vx_r == vy_r) e_pc = pc4;
      end
      GRP_SNER: begin
        if (fn != 4'h0) e_bad = 1'b1;
        else if (vx_r != vy_r) e_pc = pc4;
      end
      GRP_LD:  begin e_vwe = 1'b1; e_vval = lo_r; end
      GRP_ADD: begin e_vwe = 1'b1; e_vval = vx_r + lo_r; end
      GRP_ALU: begin
        e_vwe = 1'b1;
        case (fn)
          ALU_MOV: e_vval = vy_r;
          ALU_OR:  e_vval = vx_r | vy_r;
          ALU_AND: e_vval = vx_r & vy_r;
          ALU_XOR: e_vval = vx_r ^ vy_r;
          ALU_ADD: begin
            sum9   = {1'b0, vx_r} + {1'b0, vy_r};
            e_vval = sum9[7:0];
            e_fval = sum9[8];
            e_nxt  = NX_FLAG;
          end
          ALU_SUB: begin
            e_vval = vx_r - vy_r;
            e_fval = (vx_r >= vy_r);
            e_nxt  = NX_FLAG;
          end
          ALU_SHR: begin
            e_vval = {1'b0, vy_r[7:1]};
            e_fval = vy_r[0];
            e_nxt  = NX_FLAG;
          end
          ALU_SUBN: begin
            e_vval = vy_r - vx_r;
            e_fval = (vy_r >= vx_r);
            e_nxt  = NX_FLAG;
          end
          ALU_SHL: begin
            e_vval = {vy_r[6:0], 1'b0};
            e_fval = vy_r[7];
            e_nxt  = NX_FLAG;
          end
          default: begin
            e_vwe = 1'b0;
            e_bad = 1'b1;
          end
        endcase
      end
      GRP_LDI: begin e_iwe = 1'b1; e_ival = nnn; end
      GRP_JPV: e_pc = nnn + {4'h0, v_out};
      GRP_RND: begin e_vwe = 1'b1; e_vval = rnd_r & lo_r; end
      GRP_DRW: begin
        e_nxt = NX_DRAW;
        e_cnt = ({2'b00, fn} < row_room) ? {1'b0, fn} : row_room[4:0];
      end
      GRP_KEY: begin
        if (lo_r == LO_SKP) begin
          if (key_hit) begin
            e_keyclr = 1'b1;
            e_pc     = pc4;
          end
        end else if (lo_r == LO_SKNP) begin
          if (key_hit) e_keyclr = 1'b1;
          else         e_pc     = pc4;
        end else begin
          e_bad = 1'b1;
        end
      end
      GRP_MISC: begin
        case (lo_r)
          LO_GDT:  begin e_vwe = 1'b1; e_vval = timer_r; end
          LO_KWAIT, LO_SST: ;
          LO_SDT:  e_twe = 1'b1;
          LO_ADDI: begin e_iwe = 1'b1; e_ival = i_r + {4'h0, vx_r}; end
          LO_FONT: begin
            e_iwe  = 1'b1;
            e_ival = AW'({vx_r[3:0], 2'b00}) + AW'(vx_r[3:0]);
          end
          LO_BCD:  begin e_nxt = NX_BCD;  e_cnt = 5'd3; end
          LO_SAVE: begin e_nxt = NX_SAVE; e_cnt = {1'b0, fx} + 5'd1; end
          LO_REST: begin e_nxt = NX_REST; e_cnt = {1'b0, fx} + 5'd1; end
          default: e_bad = 1'b1;
        endcase
      end
      default: e_bad = 1'b1;
    endcase
  end

  // loop addressing
  logic [AW-1:0]    ist;
  logic [4:0]       drow;
  logic [SCR_W-1:0] sprite;
  logic             hit;
  logic [11:0]      bcd;
  logic [3:0]       digit;

  always_comb begin
    ist    = i_r + AW'(ctl.step);
    drow   = vy_r[4:0] + ctl.step;
    sprite = {m_rdata, 56'h0} >> vx_r[5:0];
    hit    = |(scr_r[drow] & sprite);
    bcd    = bcd3(vx_r);
    case (ctl.step[1:0])
      2'd0:    digit = bcd[11:8];
      2'd1:    digit = bcd[7:4];
      default: digit = bcd[3:0];
    endcase
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = ist;
    m_wdata = 8'h00;
    m_raddr = pc_r;
    v_we    = 1'b0;
    v_waddr = fx;
    v_wdata = e_vval;
    v_raddr = 4'h0;
    case (ctl.cmd)
      CMD_CLR: begin
        m_we    = 1'b1;
        m_waddr = ctl.clr_addr;
        m_wdata = (ctl.clr_addr < AW'(FONT_LEN)) ? FONT[ctl.clr_addr[6:0]] : 8'h00;
      end
      CMD_LOAD: begin
        m_we    = 1'b1;
        m_waddr = ld_addr_r;
        m_wdata = ld_data_r;
      end
      CMD_FETCH_LO: m_raddr = pc_r + 1'b1;
      CMD_RD_X:     v_raddr = fx;
      CMD_RD_Y:     v_raddr = lo_r[7:4];
      CMD_EXEC:     v_we = e_vwe;
      CMD_FLAG: begin
        v_we    = 1'b1;
        v_waddr = VF_IDX;
        v_wdata = {7'h00, flag_r};
      end
      CMD_DRAW_RD, CMD_REST_RD: m_raddr = ist;
      CMD_BCD: begin
        m_we    = 1'b1;
        m_wdata = {4'h0, digit};
      end
      CMD_SAVE_RD: v_raddr = ctl.step[3:0];
      CMD_SAVE_WR: begin
        m_we    = 1'b1;
        m_wdata = v_out;
      end
      CMD_REST_WR: begin
        v_we    = 1'b1;
        v_waddr = ctl.step[3:0];
        v_wdata = m_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_START;
      i_r         <= '0;
      sp_r        <= '0;
      timer_r     <= '0;
      keys_r      <= '0;
      v_valid_r   <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < SCR_H; r++) scr_r[r] <= '0;
    end else begin
      if (ctl.cmd == CMD_FINISH) out_valid_r <= 1'b1;
      else if (out_ready)        out_valid_r <= 1'b0;
      if (v_we) v_valid_r[v_waddr] <= 1'b1;
      case (ctl.cmd)
        CMD_MISC: begin
          if (op_r == OP_TICK && timer_r != 8'h00) timer_r <= timer_r - 1'b1;
          if (op_r == OP_KEY) keys_r[key_idx_r] <= 1'b1;
        end
        CMD_EXEC: begin
          pc_r <= e_pc;
          if (e_iwe)    i_r <= e_ival;
          if (e_twe)    timer_r <= vx_r;
          if (e_keyclr) keys_r[vx_r[3:0]] <= 1'b0;
          if (e_push)   sp_r <= sp_r + 1'b1;
          if (e_pop)    sp_r <= sp_m1;
          if (e_cls) begin
            for (int r = 0; r < SCR_H; r++) scr_r[r] <= '0;
          end
        end
        CMD_DRAW_WR: scr_r[drow] <= scr_r[drow] ^ sprite;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    v_vld_q_r <= v_valid_r[v_raddr];
    case (ctl.cmd)
      CMD_CAPTURE: begin
        op_r      <= in_operation;
        ld_addr_r <= in_load_address;
        ld_data_r <= in_load_data;
        rnd_r     <= in_random_byte;
        key_idx_r <= in_key_index;
        row_idx_r <= in_row_index;
        bad_r     <= 1'b0;
        rowout_r  <= '0;
      end
      CMD_MISC: if (op_r == OP_ROW) rowout_r <= scr_r[row_idx_r];
      CMD_FETCH_LO: hi_r <= m_rdata;
      CMD_RD_X:     lo_r <= m_rdata;
      CMD_RD_Y:     vx_r <= v_out;
      CMD_RD_0:     vy_r <= v_out;
      CMD_EXEC: begin
        flag_r <= e_fval;
        cnt_r  <= e_cnt;
        bad_r  <= e_bad;
        if (e_push) stack_r[sp_r[STK_AW-1:0]] <= pc2;
      end
      CMD_DRAW_WR: flag_r <= flag_r | hit;
      CMD_FINISH: begin
        out_pc_r  <= pc_r;
        out_row_r <= rowout_r;
        out_st_r  <= bad_r;
      end
      default: ;
    endcase
  end

  assign st.op       = op_r;
  assign st.nxt      = e_nxt;
  assign st.count    = cnt_r;
  assign st.out_busy = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_program_counter = out_pc_r;
  assign out_row_bits        = out_row_r;
  assign out_status          = out_st_r;
endmodule

FILE: rtl/core/chip8_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_executor_core
// CHIP-8 interpreter core: one result beat per item beat.
// ----------------------------------------------------------------------------
// After reset the core writes the font and zeros into main memory, one byte a
// cycle, and takes no item until that pass ends. Load, timer, key and row items
// then go through capture, dispatch, their own step and finish. An instruction
// does two fetch reads and three register reads (one each through the single
// read port of main memory and of the register file), plus a flag write, a
// read and a write per sprite row and an end check and flag on a draw, a write
// per BCD digit, and a read and a write per register for the block moves. A
// new item is taken while the last result beat waits at the output.
`include "chip8_instruction_executor_core_defines.svh"

module chip8_instruction_executor_core (
  input logic       clk,
  input logic       rst_n,
  c8x_in_if.sink    in_ch,
  c8x_out_if.source out_ch
);
  import c8x_pkg::*;

  ctl_t ctl;
  st_t  st;

  c8x_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .ctl, .st
  );

  c8x_dpath u_dpath (
    .clk, .rst_n, .ctl, .st,
    .in_operation        (in_ch.operation),
    .in_load_address     (in_ch.load_address),
    .in_load_data        (in_ch.load_data),
    .in_random_byte      (in_ch.random_byte),
    .in_key_index        (in_ch.key_index),
    .in_row_index        (in_ch.row_index),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_program_counter (out_ch.program_counter),
    .out_row_bits        (out_ch.row_bits),
    .out_status          (out_ch.status)
  );

  `C8X_ASSERT_IMP(a_no_beat_in_init, ctl.cmd == CMD_CLR, !in_ch.ready)
  `C8X_ASSERT_NXT(a_one_item_at_once, in_ch.valid && in_ch.ready, !in_ch.ready)
  `C8X_ASSERT_NXT(a_finish_shows_beat, ctl.cmd == CMD_FINISH, out_ch.valid)
endmodule

FILE: sim/tb_chip8_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// tb_chip8_instruction_executor_core
// Self-checking bench: directed instruction checks, then random programs.
// Every item is predicted by a behavioural copy of the interpreter and each
// result beat is compared in order against the expected value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_chip8_instruction_executor_core;
  import c8x_pkg::*;

  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [11:0] pc;
    logic [63:0] row;
    logic        status;
  } c8x_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  c8x_in_if  in_if ();
  c8x_out_if out_if ();

  chip8_instruction_executor_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #4 clk = ~clk;

  // interpreter state mirror
  logic [7:0]  m_mem [MEM_DEPTH];
  logic [7:0]  m_v [NREG];
  logic [11:0] m_idx;
  logic [11:0] m_pc;
  logic [11:0] m_stk [STACK_DEPTH];
  int          m_sp;
  logic [7:0]  m_dt;
  logic [15:0] m_keys;
  logic [63:0] m_scr [SCR_H];

  c8x_result_t result_q [$];
  int err_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int wdog = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  function automatic bit key_taken(input logic [7:0] k);
    if (k > 8'd15) return 1'b0;
    if (!m_keys[k[3:0]]) return 1'b0;
    m_keys[k[3:0]] = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic exec_instr(input logic [7:0] rnd);
    logic [7:0]  hi, lo, vx, vy, r;
    logic [11:0] nnn, nxt;
    logic [3:0]  x, y, n;
    logic [63:0] bits;
    logic        f, hit;
    int          xp, yp;
    hi  = m_mem[m_pc];
    lo  = m_mem[m_pc + 12'd1];
    nnn = {hi[3:0], lo};
    x   = hi[3:0];
    y   = lo[7:4];
    n   = lo[3:0];
    vx  = m_v[x];
    vy  = m_v[y];
    nxt = m_pc + 12'd2;
    m_pc = nxt;
    case (grp_t'(hi[7:4]))
      GRP_SYS: begin
        if (nnn == {4'h0, LO_CLS}) begin
          foreach (m_scr[i]) m_scr[i] = '0;
          return 1'b0;
        end
        if (nnn == {4'h0, LO_RET}) begin
          if (m_sp > 0) begin
            m_sp--;
            m_pc = m_stk[m_sp];
          end
          return 1'b0;
        end
        return 1'b1;
      end
      GRP_JP: m_pc = nnn;
      GRP_CALL: if (m_sp < STACK_DEPTH) begin
        m_stk[m_sp] = nxt;
        m_sp++;
        m_pc = nnn;
      end
      GRP_SE:  if (vx == lo) m_pc = nxt + 12'd2;
      GRP_SNE: if (vx != lo) m_pc = nxt + 12'd2;
      GRP_SER: begin
        if (n != 4'h0) return 1'b1;
        if (vx == vy) m_pc = nxt + 12'd2;
      end
      GRP_LD:  m_v[x] = lo;
      GRP_ADD: m_v[x] = vx + lo;
      GRP_ALU: begin
        case (n)
          ALU_MOV: begin m_v[x] = vy; return 1'b0; end
          ALU_OR:  begin m_v[x] = vx | vy; return 1'b0; end
          ALU_AND: begin m_v[x] = vx & vy; return 1'b0; end
          ALU_XOR: begin m_v[x] = vx ^ vy; return 1'b0; end
          ALU_ADD:  begin r = vx + vy; f = ({1'b0, vx} + {1'b0, vy}) > 9'd255; end
          ALU_SUB:  begin r = vx - vy; f = vx >= vy; end
          ALU_SHR:  begin r = vy >> 1; f = vy[0]; end
          ALU_SUBN: begin r = vy - vx; f = vy >= vx; end
          ALU_SHL:  begin r = vy << 1; f = vy[7]; end
          default: return 1'b1;
        endcase
        m_v[x] = r;
        m_v[VF_IDX] = {7'd0, f};
      end
      GRP_SNER: begin
        if (n != 4'h0) return 1'b1;
        if (vx != vy) m_pc = nxt + 12'd2;
      end
      GRP_LDI: m_idx = nnn;
      GRP_JPV: m_pc = nnn + {4'h0, m_v[0]};
      GRP_RND: m_v[x] = rnd & lo;
      GRP_DRW: begin
        xp  = vx % SCR_W;
        yp  = vy % SCR_H;
        hit = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (yp + i >= SCR_H) break;
          bits = {m_mem[m_idx + 12'(i)], 56'd0} >> xp;
          if ((m_scr[yp + i] & bits) != '0) hit = 1'b1;
          m_scr[yp + i] ^= bits;
        end
        m_v[VF_IDX] = {7'd0, hit};
      end
      GRP_KEY: begin
        if (lo == LO_SKP) begin
          if (key_taken(vx)) m_pc = nxt + 12'd2;
        end else if (lo == LO_SKNP) begin
          if (!key_taken(vx)) m_pc = nxt + 12'd2;
        end else begin
          return 1'b1;
        end
      end
      default: begin
        case (lo)
          LO_GDT:   m_v[x] = m_dt;
          LO_KWAIT: ;
          LO_SDT:   m_dt = vx;
          LO_SST:   ;
          LO_ADDI:  m_idx = m_idx + {4'h0, vx};
          LO_FONT:  m_idx = {8'h0, vx[3:0]} * 12'd5;
          LO_BCD: begin
            m_mem[m_idx]         = vx / 8'd100;
            m_mem[m_idx + 12'd1] = (vx / 8'd10) % 8'd10;
            m_mem[m_idx + 12'd2] = vx % 8'd10;
          end
          LO_SAVE: for (int i = 0; i <= x; i++) m_mem[m_idx + 12'(i)] = m_v[i];
          LO_REST: for (int i = 0; i <= x; i++) m_v[i] = m_mem[m_idx + 12'(i)];
          default: return 1'b1;
        endcase
      end
    endcase
    return 1'b0;
  endfunction

  function automatic c8x_result_t predict_item(input logic [2:0] op, input logic [11:0] addr,
      input logic [7:0] data, input logic [7:0] rnd, input logic [3:0] key,
      input logic [4:0] row);
    c8x_result_t res;
    res = '0;
    case (op)
      OP_LOAD: m_mem[addr] = data;
      OP_EXEC: res.status = exec_instr(rnd);
      OP_TICK: if (m_dt != 8'd0) m_dt--;
      OP_KEY:  m_keys[key] = 1'b1;
      OP_ROW:  res.row = m_scr[row];
      default: ;
    endcase
    res.pc = m_pc;
    return res;
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [11:0] addr, input logic [7:0] data,
      input logic [7:0] rnd, input logic [3:0] key, input logic [4:0] row);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.operation    = op;
    in_if.load_address = addr;
    in_if.load_data    = data;
    in_if.random_byte  = rnd;
    in_if.key_index    = key;
    in_if.row_index    = row;
    in_if.valid        = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    result_q.push_back(predict_item(op, addr, data, rnd, key, row));
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic load_byte(input logic [11:0] addr, input logic [7:0] data);
    send_item(OP_LOAD, addr, data, 8'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic run_instr(input logic [15:0] opc, input logic [7:0] rnd = 8'($urandom));
    load_byte(m_pc, opc[15:8]);
    load_byte(m_pc + 12'd1, opc[7:0]);
    send_item(OP_EXEC, 12'($urandom), 8'($urandom), rnd, 4'($urandom), 5'($urandom));
  endtask

  task automatic read_row(input logic [4:0] row);
    send_item(OP_ROW, 12'($urandom), 8'($urandom), 8'($urandom), 4'($urandom), row);
  endtask

  task automatic test_plain_items();
    read_row(5'd0);
    read_row(5'd31);
    for (int op = 5; op <= 7; op++)
      send_item(3'(op), 12'hFFF, 8'hFF, 8'hFF, 4'hF, 5'h1F);
    load_byte(12'hFFF, 8'hA5);
    load_byte(12'h000, 8'hF0);
    send_item(OP_KEY, '0, '0, '0, 4'h0, '0);
    send_item(OP_KEY, '0, '0, '0, 4'hF, '0);
  endtask

  task automatic test_alu();
    run_instr(16'h60FF);
    run_instr(16'h6101);
    run_instr(16'h8014);
    run_instr(16'h7001);
    run_instr(16'h8015);
    run_instr(16'h8107);
    run_instr(16'h60C3);
    run_instr(16'h8106);
    run_instr(16'h810E);
    run_instr(16'h8011);
    run_instr(16'h8012);
    run_instr(16'h8013);
    run_instr(16'h8010);
    run_instr(16'h6FF0);
    run_instr(16'h8F04);
    run_instr(16'h8018);
    run_instr(16'hC0F0, 8'h3C);
  endtask

  task automatic test_flow();
    run_instr(16'h2400);
    run_instr(16'h00EE);
    run_instr(16'h00EE);
    run_instr(16'h0123);
    run_instr(16'h3001);
    run_instr(16'h4001);
    run_instr(16'h5010);
    run_instr(16'h5011);
    run_instr(16'h9010);
    run_instr(16'h9011);
    for (int i = 0; i <= STACK_DEPTH; i++) run_instr({4'h2, m_pc});
    for (int i = 0; i <= STACK_DEPTH; i++) run_instr({8'h00, LO_RET});
    run_instr(16'h1FFE);
    run_instr(16'h6002);
    run_instr(16'hB3FE);
  endtask

  task automatic test_draw_and_memory();
    run_instr(16'h600F);
    run_instr(16'hF029);
    run_instr(16'h603C);
    run_instr(16'h611F);
    run_instr(16'hD015);
    run_instr(16'hD015);
    read_row(5'd31);
    run_instr(16'h60FF);
    run_instr(16'hAFFE);
    run_instr(16'hF033);
    run_instr(16'hF21E);
    run_instr(16'hA300);
    run_instr(16'hFF55);
    run_instr(16'hAFFE);
    run_instr(16'hF265);
    run_instr(16'h00E0);
    read_row(5'd0);
  endtask

  task automatic test_keys_timer();
    send_item(OP_KEY, '0, '0, '0, 4'h3, '0);
    run_instr(16'h6203);
    run_instr(16'hE29E);
    run_instr(16'hE2A1);
    run_instr(16'h6220);
    run_instr(16'hE29E);
    run_instr(16'hE2A1);
    run_instr(16'hE2FF);
    run_instr(16'h6302);
    run_instr(16'hF315);
    repeat (3) send_item(OP_TICK, '0, '0, '0, '0, '0);
    run_instr(16'hF407);
    run_instr(16'hF40A);
    run_instr(16'hF318);
    run_instr(16'hF4FF);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] opc;
    opc = 16'($urandom);
    case (opc[15:12])
      4'h0: case ($urandom_range(5))
        0, 1: opc[11:0] = {4'h0, LO_RET};
        2:    opc[11:0] = {4'h0, LO_CLS};
        default: ;
      endcase
      4'h5, 4'h9: if ($urandom_range(3) != 0) opc[3:0] = 4'h0;
      4'h8: if ($urandom_range(4) != 0) opc[3:0] = 4'($urandom_range(7));
      4'hD: opc[3:0] = 4'($urandom_range(6));
      4'hE: if ($urandom_range(4) != 0) opc[7:0] = $urandom_range(1) ? LO_SKP : LO_SKNP;
      4'hF: if ($urandom_range(5) != 0) begin
        case ($urandom_range(8))
          0: opc[7:0] = LO_GDT;
          1: opc[7:0] = LO_SDT;
          2: opc[7:0] = LO_ADDI;
          3: opc[7:0] = LO_FONT;
          4: opc[7:0] = LO_BCD;
          5: opc[7:0] = LO_SAVE;
          6: opc[7:0] = LO_REST;
          7: opc[7:0] = LO_KWAIT;
          default: opc[7:0] = LO_SST;
        endcase
      end
      default: ;
    endcase
    return opc;
  endfunction

  task automatic test_random_program(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: begin load_byte(12'($urandom), 8'($urandom)); sent++; end
        1: begin send_item(OP_TICK, '0, '0, '0, '0, '0); sent++; end
        2: begin send_item(OP_KEY, '0, '0, '0, 4'($urandom), '0); sent++; end
        3: begin read_row(5'($urandom)); sent++; end
        4: begin
          send_item(3'($urandom_range(7)), 12'($urandom), 8'($urandom), 8'($urandom),
                    4'($urandom), 5'($urandom));
          sent++;
        end
        default: begin run_instr(random_opcode()); sent += 3; end
      endcase
    end
  endtask

  task automatic test_drain_pause();
    wait (result_q.size() == 0);
    @(negedge clk);
  endtask

  always @(negedge clk) out_if.ready <= ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk) begin
    c8x_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (result_q.size() == 0) begin
        report("unexpected beat pc", 64'(out_if.program_counter), '0);
      end else begin
        want = result_q.pop_front();
        if (out_if.program_counter !== want.pc)
          report("program_counter", 64'(out_if.program_counter), 64'(want.pc));
        if (out_if.row_bits !== want.row) report("row_bits", out_if.row_bits, want.row);
        if (out_if.status !== want.status)
          report("status", 64'(out_if.status), 64'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_LIMIT) begin
      $display("chip8_instruction_executor_core test failed");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.operation    = '0;
    in_if.load_address = '0;
    in_if.load_data    = '0;
    in_if.random_byte  = '0;
    in_if.key_index    = '0;
    in_if.row_index    = '0;
    out_if.ready       = 1'b0;
    foreach (m_mem[i]) m_mem[i] = (i < FONT_LEN) ? FONT[i] : 8'h00;
    foreach (m_v[i]) m_v[i] = '0;
    foreach (m_stk[i]) m_stk[i] = '0;
    foreach (m_scr[i]) m_scr[i] = '0;
    m_idx  = '0;
    m_pc   = PC_START;
    m_sp   = 0;
    m_dt   = '0;
    m_keys = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_items();
    test_alu();
    test_flow();
    test_drain_pause();
    test_draw_and_memory();
    test_keys_timer();

    src_idle_pct  = 14;
    snk_stall_pct = 78;
    test_random_program(500);
    test_drain_pause();
    src_idle_pct  = 78;
    snk_stall_pct = 14;
    test_random_program(500);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    test_random_program(500);

    wait (result_q.size() == 0);
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("chip8_instruction_executor_core test passed");
    end else begin
      $display("chip8_instruction_executor_core test failed");
    end
    $finish;
  end

endmodule
